// ===== hdl/slpc_pkg.sv =====
package slpc_pkg;

    localparam int COUNTER_BITS = 16;
    localparam int PERIOD_BITS  = 16;
    localparam int CMP_BITS     = (COUNTER_BITS > PERIOD_BITS) ? COUNTER_BITS : PERIOD_BITS;
    localparam int COLOR_BITS   = 24;

    localparam logic [PERIOD_BITS-1:0] SLOW_RESET  = PERIOD_BITS'(500);
    localparam logic [PERIOD_BITS-1:0] FAST_RESET  = PERIOD_BITS'(250);
    localparam logic [PERIOD_BITS-1:0] PULSE_RESET = PERIOD_BITS'(20);
    localparam logic [PERIOD_BITS-1:0] FLASH_RESET = PERIOD_BITS'(100);

    localparam logic [4:0] PULSE_TOP    = 5'd20;
    localparam logic [4:0] PULSE_BOTTOM = 5'd2;

    // divide by 17 for 8-bit values: (v * 241) >> 12
    localparam logic [7:0] DIV17_MUL   = 8'd241;
    localparam int         DIV17_SHIFT = 12;

    localparam logic [COLOR_BITS-1:0] COLOR_BLACK  = 24'h000000;
    localparam logic [COLOR_BITS-1:0] COLOR_GREEN  = 24'h000F00;
    localparam logic [COLOR_BITS-1:0] COLOR_BLUE   = 24'h00000F;
    localparam logic [COLOR_BITS-1:0] COLOR_RED    = 24'h0F0000;
    localparam logic [COLOR_BITS-1:0] COLOR_YELLOW = 24'h0F0F00;
    localparam logic [COLOR_BITS-1:0] COLOR_WHITE  = 24'h0F0F0F;

    typedef enum logic [1:0] {
        CMD_TICK     = 2'd0,
        CMD_SET_MODE = 2'd1,
        CMD_PROGRESS = 2'd2,
        CMD_TOGGLE   = 2'd3
    } t_cmd;

    typedef enum logic [2:0] {
        MODE_OFF   = 3'd0,
        MODE_ON    = 3'd1,
        MODE_SLOW  = 3'd2,
        MODE_FAST  = 3'd3,
        MODE_PULSE = 3'd4,
        MODE_MEAS  = 3'd5,
        MODE_FLASH = 3'd6
    } t_mode;

    typedef enum logic [1:0] {
        REG_SLOW  = 2'd0,
        REG_FAST  = 2'd1,
        REG_PULSE = 2'd2,
        REG_FLASH = 2'd3
    } t_reg;

    typedef struct packed {
        t_mode                    mode;
        logic                     lit;
        logic [COUNTER_BITS-1:0]  phase;
        logic [COUNTER_BITS-1:0]  flash;
        logic [4:0]               level;
        logic                     falling;
        logic [COLOR_BITS-1:0]    base;
        logic [7:0]               prog;
    } t_state;

    typedef struct packed {
        logic [PERIOD_BITS-1:0] slow;
        logic [PERIOD_BITS-1:0] fast;
        logic [PERIOD_BITS-1:0] pulse;
        logic [PERIOD_BITS-1:0] flash;
    } t_cfg;

    function automatic logic [COLOR_BITS-1:0] mode_color(input t_mode m);
        logic [COLOR_BITS-1:0] c;
        case (m)
            MODE_ON:    c = COLOR_GREEN;
            MODE_SLOW:  c = COLOR_BLUE;
            MODE_FAST:  c = COLOR_BLUE;
            MODE_PULSE: c = COLOR_RED;
            MODE_MEAS:  c = COLOR_YELLOW;
            MODE_FLASH: c = COLOR_WHITE;
            default:    c = COLOR_BLACK;
        endcase
        return c;
    endfunction

endpackage

// ===== hdl/slpc_eval.sv =====
module slpc_eval (
    input  slpc_pkg::t_state                     i_st,
    input  slpc_pkg::t_cfg                       i_cfg,
    output slpc_pkg::t_state                     o_st,
    output logic                                 o_show,
    output logic [slpc_pkg::COLOR_BITS-1:0]      o_color
);
    import slpc_pkg::*;

    logic [CMP_BITS-1:0] phase_w;
    logic [CMP_BITS-1:0] flash_w;
    logic [CMP_BITS-1:0] per_w;
    logic [15:0]         red_prod;
    logic [15:0]         green_prod;
    logic [5:0]          lv;
    logic [4:0]          lv_fin;
    logic [6:0]          pulse_prod;

    assign phase_w    = CMP_BITS'(i_st.phase);
    assign flash_w    = CMP_BITS'(i_st.flash);
    assign red_prod   = i_st.prog * DIV17_MUL;
    assign green_prod = 8'(~i_st.prog) * DIV17_MUL;

    always_comb begin
        per_w = CMP_BITS'(i_cfg.pulse);
        if (i_st.mode == MODE_SLOW) begin
            per_w = CMP_BITS'(i_cfg.slow);
        end else if (i_st.mode == MODE_FAST) begin
            per_w = CMP_BITS'(i_cfg.fast);
        end
    end

    always_comb begin
        if (i_st.falling) begin
            lv = (i_st.level == 5'd0) ? 6'd0 : 6'({1'b0, i_st.level} - 6'd1);
        end else begin
            lv = 6'({1'b0, i_st.level} + 6'd1);
        end
        if (lv >= 6'(PULSE_TOP)) begin
            lv_fin = PULSE_TOP;
        end else if (lv <= 6'(PULSE_BOTTOM)) begin
            lv_fin = PULSE_BOTTOM;
        end else begin
            lv_fin = lv[4:0];
        end
    end

    // red scale 15/20 is exactly 3/4
    assign pulse_prod = 7'(lv_fin) * 7'd3;

    always_comb begin
        o_st    = i_st;
        o_show  = 1'b1;
        o_color = COLOR_BLACK;
        case (i_st.mode)
            MODE_OFF: begin
                o_color = COLOR_BLACK;
            end
            MODE_ON: begin
                o_color = {4'h0, red_prod[DIV17_SHIFT +: 4], 4'h0,
                           green_prod[DIV17_SHIFT +: 4], 8'h00};
            end
            MODE_SLOW, MODE_FAST: begin
                if (phase_w >= per_w) begin
                    o_st.lit   = ~i_st.lit;
                    o_st.phase = '0;
                end
                o_color = o_st.lit ? i_st.base : COLOR_BLACK;
            end
            MODE_PULSE: begin
                if (phase_w >= per_w) begin
                    o_st.level   = lv_fin;
                    o_st.falling = (lv >= 6'(PULSE_TOP)) ? 1'b1 :
                                   (lv <= 6'(PULSE_BOTTOM)) ? 1'b0 : i_st.falling;
                    o_st.phase   = '0;
                    o_color      = {3'b000, pulse_prod[6:2], 16'h0000};
                end else begin
                    o_show = 1'b0;
                end
            end
            MODE_MEAS: begin
                o_color = i_st.base;
            end
            default: begin
                if (flash_w >= CMP_BITS'(i_cfg.flash)) begin
                    o_st.mode = MODE_ON;
                    o_st.prog = 8'h00;
                    o_color   = COLOR_GREEN;
                end else begin
                    o_color = i_st.base;
                end
            end
        endcase
    end

endmodule

// ===== hdl/slpc_out.sv =====
module slpc_out (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_load,
    input  logic [slpc_pkg::COLOR_BITS-1:0]      i_color,
    input  logic                                 i_stall,
    output logic                                 o_free,
    output logic                                 o_valid,
    output logic [slpc_pkg::COLOR_BITS-1:0]      o_color
);
    import slpc_pkg::*;

    logic                  r_valid;
    logic [COLOR_BITS-1:0] r_color;

    assign o_free  = !r_valid || !i_stall;
    assign o_valid = r_valid;
    assign o_color = r_color;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_free) begin
            r_valid <= i_load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_free && i_load) begin
            r_color <= i_color;
        end
    end

endmodule

// ===== hdl/status_led_pattern_controller.sv =====
// A color result passes through the input register, then the result register;
// a stall on the result side holds its command in the input register.
// Throughput: one command per cycle while the result side is not stalled;
// commands that leave the color unchanged give no result.
// Reset (i_rst_n low, synchronous): mode off, LED black, counters cleared,
// periods back to 500/250/20/100 ms.
module status_led_pattern_controller (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_valid,
    output logic                                  o_stall,
    input  logic [1:0]                            i_command,
    input  logic [2:0]                            i_mode,
    input  logic [7:0]                            i_progress,
    output logic                                  o_valid,
    input  logic                                  i_stall,
    output logic [slpc_pkg::COLOR_BITS-1:0]       o_color,
    input  logic                                  i_cfg_we,
    input  logic [1:0]                            i_cfg_index,
    input  logic [slpc_pkg::PERIOD_BITS-1:0]      i_cfg_data
);
    import slpc_pkg::*;

    localparam logic [COUNTER_BITS-1:0] CNT_MAX = '1;

    t_cfg                  r_cfg;
    t_state                r_st;
    t_state                n_st;
    t_state                pre_st;
    t_state                ev_st;
    logic [COLOR_BITS-1:0] r_shown;
    logic                  r_in_valid;
    t_cmd                  r_cmd;
    logic [2:0]            r_mode;
    logic [7:0]            r_prog;
    logic                  eval_en;
    logic                  set_req;
    logic [2:0]            m_req;
    logic                  ev_show;
    logic [COLOR_BITS-1:0] ev_color;
    logic                  out_free;
    logic                  advance;
    logic                  load;

    assign advance = r_in_valid && out_free;
    assign o_stall = r_in_valid && !out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_stall) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && !o_stall) begin
            r_cmd  <= t_cmd'(i_command);
            r_mode <= i_mode;
            r_prog <= i_progress;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.slow  <= SLOW_RESET;
            r_cfg.fast  <= FAST_RESET;
            r_cfg.pulse <= PULSE_RESET;
            r_cfg.flash <= FLASH_RESET;
        end else if (i_cfg_we) begin
            case (t_reg'(i_cfg_index))
                REG_SLOW:  r_cfg.slow  <= i_cfg_data;
                REG_FAST:  r_cfg.fast  <= i_cfg_data;
                REG_PULSE: r_cfg.pulse <= i_cfg_data;
                default:   r_cfg.flash <= i_cfg_data;
            endcase
        end
    end

    always_comb begin
        pre_st  = r_st;
        eval_en = 1'b0;
        set_req = 1'b0;
        m_req   = r_mode;
        case (r_cmd)
            CMD_TICK: begin
                if (r_st.phase != CNT_MAX) begin
                    pre_st.phase = r_st.phase + 1'b1;
                end
                if (r_st.flash != CNT_MAX) begin
                    pre_st.flash = r_st.flash + 1'b1;
                end
                eval_en = 1'b1;
            end
            CMD_SET_MODE: begin
                set_req = 1'b1;
            end
            CMD_PROGRESS: begin
                pre_st.prog = r_prog;
            end
            default: begin
                set_req = 1'b1;
                m_req   = (r_st.mode == MODE_ON) ? MODE_OFF : MODE_ON;
            end
        endcase
        if (set_req && m_req <= MODE_FLASH && m_req != r_st.mode) begin
            pre_st.mode  = t_mode'(m_req);
            pre_st.lit   = (m_req != MODE_OFF);
            pre_st.level = (m_req == MODE_OFF) ? 5'd0 : PULSE_TOP;
            pre_st.base  = mode_color(t_mode'(m_req));
            pre_st.phase = '0;
            if (m_req == MODE_FLASH) begin
                pre_st.flash = '0;
            end
            eval_en = 1'b1;
        end
    end

    slpc_eval u_eval (
        .i_st    (pre_st),
        .i_cfg   (r_cfg),
        .o_st    (ev_st),
        .o_show  (ev_show),
        .o_color (ev_color)
    );

    assign n_st = eval_en ? ev_st : pre_st;
    assign load = advance && eval_en && ev_show && (ev_color != r_shown);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st    <= '0;
            r_shown <= COLOR_BLACK;
        end else if (advance) begin
            r_st <= n_st;
            if (load) begin
                r_shown <= ev_color;
            end
        end
    end

    slpc_out u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (load),
        .i_color (ev_color),
        .i_stall (i_stall),
        .o_free  (out_free),
        .o_valid (o_valid),
        .o_color (o_color)
    );

    a_pulse_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_st.mode == MODE_PULSE) |-> (r_st.level >= PULSE_BOTTOM && r_st.level <= PULSE_TOP))
        else $error("pulse level out of range");

    a_off_dark: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_st.mode == MODE_OFF) |-> (!r_st.lit && r_shown == COLOR_BLACK))
        else $error("off mode with lit phase or shown color");

    a_load_shown: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        load |=> (o_valid && o_color == r_shown))
        else $error("result register disagrees with shown color");

    a_hold_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !out_free) |=> (r_in_valid && $stable(r_st)))
        else $error("state changed while command held");

endmodule
